### src/esc_pkg.sv
// Shared constants and calendar helpers for the epoch seconds to calendar converter.
// No dependencies; imported by epoch_seconds_to_calendar_top.
`default_nettype none

package esc_pkg;

    localparam int unsigned SECS_PER_DAY  = 86400;
    localparam int unsigned SECS_PER_HOUR = 3600;
    localparam int unsigned SECS_PER_MIN  = 60;
    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam int unsigned EPOCH_WDAY    = 4;    // 1970-01-01 was a Thursday
    localparam int unsigned EPOCH_YEAR    = 70;   // 1970, counted from 1900
    localparam int unsigned CENTURY_2100  = 200;  // 2100, counted from 1900
    localparam int unsigned LAST_MONTH    = 11;   // December

    // Quotient widths set the number of shift-subtract steps in each division
    localparam int unsigned DAY_QW  = 16;         // days since epoch < 2^16
    localparam int unsigned HOUR_QW = 5;
    localparam int unsigned MIN_QW  = 6;
    localparam int unsigned WDAY_QW = 13;         // (days + 4) / 7 < 2^13

    localparam int unsigned DIV_W = 17;           // widest divisor, 86400
    localparam int unsigned ACC_W = 33;           // remainder plus borrow bit

    // Year counted from 1900, only 1970 to 2106 reached. Among those only 2000
    // (divisible by 400) and 2100 (divisible by 100 only) are century years.
    function automatic logic is_leap(input logic [7:0] yr);
        is_leap = (yr[1:0] == 2'b00) && (yr != 8'(CENTURY_2100));
    endfunction

    function automatic logic [8:0] year_len(input logic [7:0] yr);
        year_len = is_leap(yr) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] month_len(input logic [7:0] yr, input logic [3:0] mon);
        case (mon)
            4'd1:                      month_len = is_leap(yr) ? 5'd29 : 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:   month_len = 5'd30;
            default:                   month_len = 5'd31;
        endcase
    endfunction

endpackage

`default_nettype wire

### src/epoch_seconds_to_calendar_top.sv
// Epoch seconds to UTC calendar converter, top level.
// Depends on esc_pkg for constants and the leap-year and month-length helpers.
//
// Channel   Signals                          Direction   Word
// input     in_valid / in_ready              into block  epoch_seconds, 32 bits unsigned
// output    out_valid / out_ready            out of block  eight calendar fields
//
// One word runs shift-subtract divisions for days, hours, minutes and weekday, then
// walks the years past 1970 (up to 136) and the months past January (up to 11), the
// year walk closed by one failing compare and the month walk by one or at December,
// and is handed over: the edge that loads the output register also raises in_ready.
// A single 33-bit compare-subtract unit does every step.
// in_ready is high only while the sequencer is idle; reset sets it and clears the output valid.
// A finished word waits in the output register; the next word is accepted meanwhile
// and holds in its final state until the output register is free.
`default_nettype none

module epoch_seconds_to_calendar_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [31:0] epoch_seconds,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [4:0]       hour_of_day,
    output logic [5:0]       minute_of_hour,
    output logic [5:0]       second_of_minute,
    output logic [4:0]       day_of_month,
    output logic [3:0]       month_index,
    output logic [7:0]       years_since_1900,
    output logic [2:0]       week_day,
    output logic [8:0]       year_day
);

    import esc_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DAY   = 3'd1;
    localparam logic [2:0] S_HOUR  = 3'd2;
    localparam logic [2:0] S_MIN   = 3'd3;
    localparam logic [2:0] S_WDAY  = 3'd4;
    localparam logic [2:0] S_YEAR  = 3'd5;
    localparam logic [2:0] S_MONTH = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    // Sequencer
    logic [2:0]          state_reg, state_next;
    logic [3:0]          cnt_reg, cnt_next;

    // Working registers
    logic [31:0]         rem_reg, rem_next;
    logic [DAY_QW-1:0]   quo_reg, quo_next;
    logic [DAY_QW-1:0]   days_reg, days_next;
    logic [4:0]          hour_reg, hour_next;
    logic [5:0]          min_reg, min_next;
    logic [5:0]          sec_reg, sec_next;
    logic [2:0]          wday_reg, wday_next;
    logic [7:0]          year_reg, year_next;
    logic [3:0]          month_reg, month_next;
    logic [8:0]          yday_reg, yday_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic                load_out;
    logic [4:0]          o_hour_reg;
    logic [5:0]          o_min_reg;
    logic [5:0]          o_sec_reg;
    logic [4:0]          o_mday_reg;
    logic [3:0]          o_month_reg;
    logic [7:0]          o_year_reg;
    logic [2:0]          o_wday_reg;
    logic [8:0]          o_yday_reg;

    // Shared compare-subtract unit
    logic [DIV_W-1:0]    div_sel;
    logic [ACC_W-1:0]    div_shifted;
    logic [ACC_W-1:0]    diff;
    logic                ge;

    assign in_ready = (state_reg == S_IDLE);

    // Pick the divisor for the current phase; year and month steps use no shift
    always_comb
    begin
        case (state_reg)
            S_DAY:   div_sel = DIV_W'(SECS_PER_DAY);
            S_HOUR:  div_sel = DIV_W'(SECS_PER_HOUR);
            S_MIN:   div_sel = DIV_W'(SECS_PER_MIN);
            S_WDAY:  div_sel = DIV_W'(DAYS_PER_WEEK);
            S_YEAR:  div_sel = DIV_W'(year_len(year_reg));
            S_MONTH: div_sel = DIV_W'(month_len(year_reg, month_reg));
            default: div_sel = '0;
        endcase
    end

    assign div_shifted = ACC_W'(div_sel) << cnt_reg;
    assign diff        = {1'b0, rem_reg} - div_shifted;
    assign ge          = ~diff[ACC_W-1];

    // Only hand over when the output register is empty or being drained
    assign load_out = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        days_next  = days_reg;
        hour_next  = hour_reg;
        min_next   = min_reg;
        sec_next   = sec_reg;
        wday_next  = wday_reg;
        year_next  = year_reg;
        month_next = month_reg;
        yday_next  = yday_reg;

        // Restoring division step shared by the four division phases
        if (state_reg inside {S_DAY, S_HOUR, S_MIN, S_WDAY})
        begin
            quo_next = {quo_reg[DAY_QW-2:0], ge};
            if (ge)
            begin
                rem_next = diff[31:0];
            end
            cnt_next = cnt_reg - 4'd1;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    rem_next   = epoch_seconds;
                    quo_next   = '0;
                    cnt_next   = 4'(DAY_QW - 1);
                    state_next = S_DAY;
                end
            end
            S_DAY:
            begin
                if (cnt_reg == 4'd0)
                begin
                    days_next  = quo_next;
                    cnt_next   = 4'(HOUR_QW - 1);
                    state_next = S_HOUR;
                end
            end
            S_HOUR:
            begin
                if (cnt_reg == 4'd0)
                begin
                    hour_next  = quo_next[HOUR_QW-1:0];
                    cnt_next   = 4'(MIN_QW - 1);
                    state_next = S_MIN;
                end
            end
            S_MIN:
            begin
                if (cnt_reg == 4'd0)
                begin
                    min_next   = quo_next[MIN_QW-1:0];
                    sec_next   = rem_next[5:0];
                    // Day zero is a Thursday: bias the day count before reducing by 7
                    rem_next   = 32'(days_reg) + 32'(EPOCH_WDAY);
                    cnt_next   = 4'(WDAY_QW - 1);
                    state_next = S_WDAY;
                end
            end
            S_WDAY:
            begin
                if (cnt_reg == 4'd0)
                begin
                    wday_next  = rem_next[2:0];
                    rem_next   = 32'(days_reg);
                    year_next  = 8'(EPOCH_YEAR);
                    cnt_next   = 4'd0;
                    state_next = S_YEAR;
                end
            end
            S_YEAR:
            begin
                // Drop whole years until fewer days remain than this year holds
                if (ge)
                begin
                    rem_next  = diff[31:0];
                    year_next = year_reg + 8'd1;
                end
                else
                begin
                    yday_next  = rem_reg[8:0];
                    month_next = 4'd0;
                    state_next = S_MONTH;
                end
            end
            S_MONTH:
            begin
                if (ge && (month_reg < 4'(LAST_MONTH)))
                begin
                    rem_next   = diff[31:0];
                    month_next = month_reg + 4'd1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Working payload
    always_ff @(posedge clk)
    begin
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        days_reg  <= days_next;
        hour_reg  <= hour_next;
        min_reg   <= min_next;
        sec_reg   <= sec_next;
        wday_reg  <= wday_next;
        year_reg  <= year_next;
        month_reg <= month_next;
        yday_reg  <= yday_next;
    end

    // Output payload: hold until the next hand-over
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            o_hour_reg  <= hour_reg;
            o_min_reg   <= min_reg;
            o_sec_reg   <= sec_reg;
            o_mday_reg  <= rem_reg[4:0] + 5'd1;
            o_month_reg <= month_reg;
            o_year_reg  <= year_reg;
            o_wday_reg  <= wday_reg;
            o_yday_reg  <= yday_reg;
        end
    end

    assign out_valid        = out_valid_reg;
    assign hour_of_day      = o_hour_reg;
    assign minute_of_hour   = o_min_reg;
    assign second_of_minute = o_sec_reg;
    assign day_of_month     = o_mday_reg;
    assign month_index      = o_month_reg;
    assign years_since_1900 = o_year_reg;
    assign week_day         = o_wday_reg;
    assign year_day         = o_yday_reg;

`ifndef SYNTHESIS
    // An accepted word always starts the day division from its top quotient bit
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_DAY && cnt_reg == 4'(DAY_QW - 1)))
        else $error("day division did not start after accept");

    // A new output word appears only from a hand-over out of the final state
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("output valid raised outside hand-over");

    // Time-of-day fields stay in range whenever a word is offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (hour_of_day < 5'd24 && minute_of_hour < 6'd60 &&
                       second_of_minute < 6'd60 && week_day < 3'd7))
        else $error("time-of-day or weekday out of range");

    // The year walk never passes 2106
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_YEAR || state_reg == S_MONTH) |-> (year_reg <= 8'd206))
        else $error("year counter ran past range");
`endif

endmodule

`default_nettype wire

### tb/tb_epoch_seconds_to_calendar_top.sv
// Self-checking bench for epoch_seconds_to_calendar_top: drives seconds counts, predicts
// each calendar word in a scoreboard class and checks every returned word field by field.
// Depends only on the RTL under src/.
`default_nettype none

module tb_epoch_seconds_to_calendar_top;

    localparam int unsigned DAY_SECS     = 86400;
    localparam int unsigned LAST_DAY     = 49709;    // last whole day below 2^32 seconds
    localparam int unsigned RANDOM_WORDS = 450;
    localparam int unsigned TAIL_WORDS   = 60;       // final stretch runs without idling
    localparam int unsigned PHASE_WORDS  = 40;       // idling is switched per phase
    localparam int unsigned DRAIN_CYCLES = 250;      // beyond the longest conversion
    // Sized well above every word taking its longest conversion, idle gap and output stall.
    localparam int unsigned CYCLE_LIMIT  = 600000;

    // One calendar word, fields in the order of the output ports
    typedef struct packed {
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
        logic [4:0] mday;
        logic [3:0] month;
        logic [7:0] year;
        logic [2:0] wday;
        logic [8:0] yday;
    } calendar_t;

    typedef struct {
        logic [31:0] secs;
        calendar_t   cal;
    } expected_word_t;

    // Holds the calendar words still owed by the block, oldest first
    class calendar_scoreboard;
        localparam int unsigned FEBRUARY  = 1;
        localparam int unsigned APRIL     = 3;
        localparam int unsigned JUNE      = 5;
        localparam int unsigned SEPTEMBER = 8;
        localparam int unsigned NOVEMBER  = 10;
        localparam int unsigned DECEMBER  = 11;
        localparam int unsigned PRINT_CAP = 40;

        expected_word_t owed_words[$];
        int unsigned    fails;

        function new();
            fails = 0;
        endfunction

        function bit gregorian_leap(int unsigned yr);
            return (yr % 4 == 0) && ((yr % 100 != 0) || (yr % 400 == 0));
        endfunction

        function int unsigned days_in_month(int unsigned yr, int unsigned mon);
            if (mon == FEBRUARY)
                return gregorian_leap(yr) ? 29 : 28;
            if (mon == APRIL || mon == JUNE || mon == SEPTEMBER || mon == NOVEMBER)
                return 30;
            return 31;
        endfunction

        // Break a seconds count into its calendar fields, walking years then months
        function calendar_t to_calendar(logic [31:0] secs);
            int unsigned tod;
            int unsigned days;
            int unsigned yr;
            int unsigned mon;
            calendar_t   c;
            tod    = secs % DAY_SECS;
            days   = secs / DAY_SECS;
            c.wday = 3'((days + 4) % 7);             // day zero fell on a Thursday
            c.hour   = 5'(tod / 3600);
            c.minute = 6'((tod % 3600) / 60);
            c.second = 6'(tod % 60);
            yr = 1970;
            while (days >= (gregorian_leap(yr) ? 366 : 365)) begin
                days -= gregorian_leap(yr) ? 366 : 365;
                yr++;
            end
            c.yday = 9'(days);
            mon = 0;
            while (mon < DECEMBER && days >= days_in_month(yr, mon)) begin
                days -= days_in_month(yr, mon);
                mon++;
            end
            c.mday  = 5'(days + 1);
            c.month = 4'(mon);
            c.year  = 8'(yr - 1900);
            return c;
        endfunction

        function int unsigned pending();
            return owed_words.size();
        endfunction

        function void note_word(logic [31:0] secs);
            expected_word_t w;
            w.secs = secs;
            w.cal  = to_calendar(secs);
            owed_words.push_back(w);
        endfunction

        task report(string what);
            if (fails < PRINT_CAP)
                $display("mismatch: %s", what);
            fails++;
        endtask

        task check_word(calendar_t got);
            expected_word_t w;
            if (owed_words.size() == 0)
            begin
                report($sformatf("calendar word %h arrived with nothing owed", got));
                return;
            end
            w = owed_words.pop_front();
            if (got.hour != w.cal.hour)
                report($sformatf("secs %0d hour_of_day %0d, want %0d",
                                 w.secs, got.hour, w.cal.hour));
            if (got.minute != w.cal.minute)
                report($sformatf("secs %0d minute_of_hour %0d, want %0d",
                                 w.secs, got.minute, w.cal.minute));
            if (got.second != w.cal.second)
                report($sformatf("secs %0d second_of_minute %0d, want %0d",
                                 w.secs, got.second, w.cal.second));
            if (got.mday != w.cal.mday)
                report($sformatf("secs %0d day_of_month %0d, want %0d",
                                 w.secs, got.mday, w.cal.mday));
            if (got.month != w.cal.month)
                report($sformatf("secs %0d month_index %0d, want %0d",
                                 w.secs, got.month, w.cal.month));
            if (got.year != w.cal.year)
                report($sformatf("secs %0d years_since_1900 %0d, want %0d",
                                 w.secs, got.year, w.cal.year));
            if (got.wday != w.cal.wday)
                report($sformatf("secs %0d week_day %0d, want %0d",
                                 w.secs, got.wday, w.cal.wday));
            if (got.yday != w.cal.yday)
                report($sformatf("secs %0d year_day %0d, want %0d",
                                 w.secs, got.yday, w.cal.yday));
        endtask
    endclass

    logic        clk           = 1'b0;
    logic        rst_n         = 1'b0;
    logic        in_valid      = 1'b0;
    logic [31:0] epoch_seconds = '0;
    logic        out_ready     = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [4:0]  hour_of_day;
    logic [5:0]  minute_of_hour;
    logic [5:0]  second_of_minute;
    logic [4:0]  day_of_month;
    logic [3:0]  month_index;
    logic [7:0]  years_since_1900;
    logic [2:0]  week_day;
    logic [8:0]  year_day;

    bit                 idle_on = 1'b0;    // idling allowed in the current phase
    int unsigned        cycle_count = 0;
    calendar_scoreboard board;

    // Boundary words: day, year and century edges, leap days, 2^31 and the top of range
    logic [31:0] directed_words[$] = '{
        32'd0,          32'd1,          32'd59,         32'd60,
        32'd3599,       32'd3600,       32'd86399,      32'd86400,
        32'd31535999,   32'd31536000,   32'd68169600,   32'd946684799,
        32'd951782400,  32'd951868800,  32'd978307199,  32'd2147483647,
        32'd2147483648, 32'd4107456000, 32'd4107542400, 32'd4133980799,
        32'hAAAAAAAA,   32'h55555555,   32'hFFFFFFFE,   32'hFFFFFFFF
    };

    epoch_seconds_to_calendar_top u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .epoch_seconds    (epoch_seconds),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .hour_of_day      (hour_of_day),
        .minute_of_hour   (minute_of_hour),
        .second_of_minute (second_of_minute),
        .day_of_month     (day_of_month),
        .month_index      (month_index),
        .years_since_1900 (years_since_1900),
        .week_day         (week_day),
        .year_day         (year_day)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Mix of uniform counts, whole-day edges, the 2100 neighbourhood and late-day seconds
    function automatic logic [31:0] random_seconds();
        int unsigned pick;
        logic [63:0] wide;
        pick = $urandom_range(0, 9);
        wide = 64'($urandom_range(0, LAST_DAY)) * 64'(DAY_SECS);
        if (pick < 4)
            return $urandom;
        else if (pick < 6)
            return 32'(wide + (($urandom_range(0, 1) != 0) ? 64'd86399 : 64'd0));
        else if (pick < 8)
            return $urandom_range(32'd4070908800, 32'hFFFFFFFF);
        else
            return 32'(wide + 64'($urandom_range(86340, 86399)));
    endfunction

    // Hold the word until the block takes it, then note it for prediction
    task automatic send_word(input logic [31:0] secs);
        in_valid      <= 1'b1;
        epoch_seconds <= secs;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.note_word(secs);
    endtask

    // Drop valid for a burst. Sometimes wait for the block to go idle first, so the gap
    // lands while it sits waiting rather than while it is still converting.
    task automatic idle_input();
        if (idle_on && $urandom_range(0, 2) == 0)
        begin
            in_valid      <= 1'b0;
            epoch_seconds <= $urandom;
            if ($urandom_range(0, 1) != 0)
            begin
                @(posedge clk);
                while (!in_ready)
                    @(posedge clk);
            end
            repeat ($urandom_range(1, 10))
                @(posedge clk);
        end
    endtask

    // Receiver: stall out_ready in random bursts while idling is on, otherwise hold it high
    initial
    begin
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 10))
                    @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Check every accepted calendar word; inputs change only after the edge, so sampling
    // here sees the pre-edge handshake
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_word({hour_of_day, minute_of_hour, second_of_minute, day_of_month,
                              month_index, years_since_1900, week_day, year_day});
    end

    // Watchdog: end the run with a fail once the cycle limit is reached, as when the block stops handing back words
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int unsigned total;
        int unsigned i;
        board = new();
        total = directed_words.size() + RANDOM_WORDS;

        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words first, then random; idling is redrawn each phase and is off
        // throughout the tail so back-to-back traffic is covered too
        for (i = 0; i < total; i++)
        begin
            if (i % PHASE_WORDS == 0)
                idle_on = ($urandom_range(0, 2) != 0);
            if (i + TAIL_WORDS >= total)
                idle_on = 1'b0;
            if (i < directed_words.size())
                send_word(directed_words[i]);
            else
                send_word(random_seconds());
            idle_input();
        end
        in_valid <= 1'b0;

        // Wait for every owed word, then allow a conversion's worth of quiet
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (board.fails == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

### epoch_seconds_to_calendar_top.f
src/esc_pkg.sv
src/epoch_seconds_to_calendar_top.sv
tb/tb_epoch_seconds_to_calendar_top.sv
